[design/pair_invariant_mass_unit_macros.svh]
// Assertion helpers for the pair invariant mass unit.
`ifndef PAIR_INVARIANT_MASS_UNIT_MACROS_SVH
`define PAIR_INVARIANT_MASS_UNIT_MACROS_SVH

// Checked outside reset.
`define PIM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PIM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/pim_pkg.sv]
`timescale 1ns / 1ps

package pim_pkg;

    localparam int WORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF = 16;

    // Pion mass register
    localparam int PMASS_BITS = 16;

    // Neutral pion mass 0.1349768 GeV, scaled by 10^7
    localparam longint unsigned PMASS_E7 = 64'd1349768;
    localparam longint unsigned SCALE_E7 = 64'd10000000;

    // Axes of a momentum
    localparam int AXES = 3;

    // Mass lanes: kk, k+ pi-, k- pi+, k+ pi0, k- pi0
    localparam int MASS_LANES = 5;

endpackage

[design/pim_isqrt.sv]
`timescale 1ns / 1ps

// Pipelined floor square root, one root bit per stage, MSB first.
module pim_isqrt #(
    parameter int LANES     = 1,
    parameter int ROOT_BITS = 8,
    parameter int SIDE_BITS = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       valid_i,
    input  logic [2*ROOT_BITS-1:0]     rad_i [LANES],
    input  logic [SIDE_BITS-1:0]       side_i,
    output logic                       valid_o,
    output logic [ROOT_BITS-1:0]       root_o [LANES],
    output logic [SIDE_BITS-1:0]       side_o
);

    localparam int RW = 2 * ROOT_BITS;

    logic [RW-1:0]        rem_reg   [ROOT_BITS][LANES];
    logic [ROOT_BITS-1:0] root_reg  [ROOT_BITS][LANES];
    logic [SIDE_BITS-1:0] side_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] valid_reg;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        localparam int B = ROOT_BITS - 1 - k;

        logic [RW-1:0]        rem_in   [LANES];
        logic [ROOT_BITS-1:0] root_in  [LANES];
        logic [RW-1:0]        rem_next [LANES];
        logic [ROOT_BITS-1:0] root_next[LANES];
        logic                 valid_in;
        logic [SIDE_BITS-1:0] side_in;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l]  = rad_i[l];
                    root_in[l] = '0;
                end
                valid_in = valid_i;
                side_in  = side_i;
            end
        end else begin : g_rest
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l]  = rem_reg[k-1][l];
                    root_in[l] = root_reg[k-1][l];
                end
                valid_in = valid_reg[k-1];
                side_in  = side_reg[k-1];
            end
        end

        // trial = (2*root + 2^B) * 2^B
        always_comb begin
            logic [RW-1:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = (RW'(root_in[l]) << (B + 1)) | (RW'(1) << (2 * B));
                if (rem_in[l] >= trial) begin
                    rem_next[l]  = rem_in[l] - trial;
                    root_next[l] = root_in[l] | (ROOT_BITS'(1) << B);
                end else begin
                    rem_next[l]  = rem_in[l];
                    root_next[l] = root_in[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k][l]  <= rem_next[l];
                    root_reg[k][l] <= root_next[l];
                end
                side_reg[k] <= side_in;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            root_o[l] = root_reg[ROOT_BITS-1][l];
        end
    end
    assign side_o  = side_reg[ROOT_BITS-1];
    assign valid_o = valid_reg[ROOT_BITS-1];

endmodule

[design/pair_invariant_mass_unit.sv]
`timescale 1ns / 1ps

// Pair invariant mass unit. Takes one candidate (K+, K-, pi0 four-vectors,
// signed fixed point with FRAC_BITS fraction bits) per request and returns
// five floor-rounded pair masses sqrt(E^2 - |p|^2): K+K-, K+ with the K-
// taken as a pion, K- with the K+ taken as a pion, K+pi0 and K-pi0. The
// pion-hypothesis energies are rebuilt as sqrt(p^2 + m^2) with m from the
// pion mass register (cfg_we / cfg_wdata; the user must write it only while
// idle, the block itself does not enforce this). A negative squared mass
// gives mass 0 with its neg flag set; masses above 2^(WORD_BITS-1)-1
// saturate. Throughput is one candidate per cycle while the output is not
// stalled. The pipe is two bit-per-stage square root pipelines (WORD_BITS+1
// and WORD_BITS+2 stages) plus seven arithmetic and register stages. The
// whole pipe advances together: it holds only while a result sits in the
// output register and m_ready is low, so s_ready drops in exactly that case.
module pair_invariant_mass_unit #(
    parameter int WORD_BITS = pim_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = pim_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic [pim_pkg::PMASS_BITS-1:0] cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [WORD_BITS-1:0]   s_kplus_px,
    input  logic signed [WORD_BITS-1:0]   s_kplus_py,
    input  logic signed [WORD_BITS-1:0]   s_kplus_pz,
    input  logic [WORD_BITS-2:0]          s_kplus_energy,
    input  logic signed [WORD_BITS-1:0]   s_kminus_px,
    input  logic signed [WORD_BITS-1:0]   s_kminus_py,
    input  logic signed [WORD_BITS-1:0]   s_kminus_pz,
    input  logic [WORD_BITS-2:0]          s_kminus_energy,
    input  logic signed [WORD_BITS-1:0]   s_pizero_px,
    input  logic signed [WORD_BITS-1:0]   s_pizero_py,
    input  logic signed [WORD_BITS-1:0]   s_pizero_pz,
    input  logic [WORD_BITS-2:0]          s_pizero_energy,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [WORD_BITS-2:0]          m_mass_kk,
    output logic [WORD_BITS-2:0]          m_mass_kplus_piminus,
    output logic [WORD_BITS-2:0]          m_mass_kminus_piplus,
    output logic [WORD_BITS-2:0]          m_mass_kplus_pizero,
    output logic [WORD_BITS-2:0]          m_mass_kminus_pizero,
    output logic                          m_neg_kk,
    output logic                          m_neg_kplus_piminus,
    output logic                          m_neg_kminus_piplus,
    output logic                          m_neg_kplus_pizero,
    output logic                          m_neg_kminus_pizero
);

    localparam int W   = WORD_BITS;
    localparam int NA  = pim_pkg::AXES;
    localparam int NL  = pim_pkg::MASS_LANES;
    localparam int PMB = pim_pkg::PMASS_BITS;
    localparam int EW  = W - 1;           // input energy
    localparam int SQ1 = 2 * W;           // single-track component square
    localparam int SQ2 = 2 * W + 2;       // pair component square, |p|^2 sums
    localparam int PR  = W + 1;           // rebuilt pion energy
    localparam int EB  = W + 2;           // pair energy
    localparam int E2W = 2 * W + 4;       // pair energy squared
    localparam int MR  = W + 2;           // mass root
    localparam int SIDE1 = 3 * EW + 3 * SQ2;

    // Pion mass reset: round-to-nearest, saturated to the register width
    localparam longint unsigned PM_RAW =
        ((pim_pkg::PMASS_E7 << FRAC_BITS) + pim_pkg::SCALE_E7 / 2) / pim_pkg::SCALE_E7;
    localparam logic [PMB-1:0] PM_RESET =
        (PM_RAW > ((64'd1 << PMB) - 1)) ? {PMB{1'b1}} : PMB'(PM_RAW);
    localparam logic [W-2:0] MASS_MAX = {(W-1){1'b1}};

    // ---------------------------------------------------------------
    // Config register and global pipe enable
    // ---------------------------------------------------------------
    logic [PMB-1:0] pion_mass_reg;
    logic           en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pion_mass_reg <= PM_RESET;
        end else if (cfg_we) begin
            pion_mass_reg <= cfg_wdata;
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------------------------------------------------------
    // Stage 1: momentum sums and magnitudes
    // ---------------------------------------------------------------
    logic signed [W-1:0] kp [NA];
    logic signed [W-1:0] km [NA];
    logic signed [W-1:0] pz [NA];

    assign kp[0] = s_kplus_px;
    assign kp[1] = s_kplus_py;
    assign kp[2] = s_kplus_pz;
    assign km[0] = s_kminus_px;
    assign km[1] = s_kminus_py;
    assign km[2] = s_kminus_pz;
    assign pz[0] = s_pizero_px;
    assign pz[1] = s_pizero_py;
    assign pz[2] = s_pizero_pz;

    logic [W-1:0] kp_mag_next  [NA];
    logic [W-1:0] km_mag_next  [NA];
    logic [W:0]   kk_mag_next  [NA];
    logic [W:0]   kpz_mag_next [NA];
    logic [W:0]   kmz_mag_next [NA];

    logic [W-1:0] kp_mag_reg  [NA];
    logic [W-1:0] km_mag_reg  [NA];
    logic [W:0]   kk_mag_reg  [NA];
    logic [W:0]   kpz_mag_reg [NA];
    logic [W:0]   kmz_mag_reg [NA];
    logic [EW-1:0] kpe1_reg, kme1_reg, ze1_reg;
    logic          v1_reg;

    // magnitude of the most negative value still fits as unsigned
    always_comb begin
        logic signed [W:0] s_kk, s_kpz, s_kmz;
        for (int a = 0; a < NA; a++) begin
            kp_mag_next[a] = kp[a][W-1] ? W'(-kp[a]) : W'(kp[a]);
            km_mag_next[a] = km[a][W-1] ? W'(-km[a]) : W'(km[a]);
            s_kk  = (W+1)'(kp[a]) + (W+1)'(km[a]);
            s_kpz = (W+1)'(kp[a]) + (W+1)'(pz[a]);
            s_kmz = (W+1)'(km[a]) + (W+1)'(pz[a]);
            kk_mag_next[a]  = s_kk[W]  ? (W+1)'(-s_kk)  : (W+1)'(s_kk);
            kpz_mag_next[a] = s_kpz[W] ? (W+1)'(-s_kpz) : (W+1)'(s_kpz);
            kmz_mag_next[a] = s_kmz[W] ? (W+1)'(-s_kmz) : (W+1)'(s_kmz);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < NA; a++) begin
                kp_mag_reg[a]  <= kp_mag_next[a];
                km_mag_reg[a]  <= km_mag_next[a];
                kk_mag_reg[a]  <= kk_mag_next[a];
                kpz_mag_reg[a] <= kpz_mag_next[a];
                kmz_mag_reg[a] <= kmz_mag_next[a];
            end
            kpe1_reg <= s_kplus_energy;
            kme1_reg <= s_kminus_energy;
            ze1_reg  <= s_pizero_energy;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: component squares, pion mass squared
    // ---------------------------------------------------------------
    logic [SQ1-1:0] sq_kp_reg  [NA];
    logic [SQ1-1:0] sq_km_reg  [NA];
    logic [SQ2-1:0] sq_kk_reg  [NA];
    logic [SQ2-1:0] sq_kpz_reg [NA];
    logic [SQ2-1:0] sq_kmz_reg [NA];
    logic [2*PMB-1:0] m2_reg;
    logic [EW-1:0]  kpe2_reg, kme2_reg, ze2_reg;
    logic           v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < NA; a++) begin
                sq_kp_reg[a]  <= kp_mag_reg[a] * kp_mag_reg[a];
                sq_km_reg[a]  <= km_mag_reg[a] * km_mag_reg[a];
                sq_kk_reg[a]  <= kk_mag_reg[a] * kk_mag_reg[a];
                sq_kpz_reg[a] <= kpz_mag_reg[a] * kpz_mag_reg[a];
                sq_kmz_reg[a] <= kmz_mag_reg[a] * kmz_mag_reg[a];
            end
            m2_reg   <= pion_mass_reg * pion_mass_reg;
            kpe2_reg <= kpe1_reg;
            kme2_reg <= kme1_reg;
            ze2_reg  <= ze1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: |p|^2 sums; pion-hypothesis radicands add m^2
    // ---------------------------------------------------------------
    logic [SQ2-1:0] rad_kp_reg, rad_km_reg;
    logic [SQ2-1:0] p2_kk3_reg, p2_kpz3_reg, p2_kmz3_reg;
    logic [EW-1:0]  kpe3_reg, kme3_reg, ze3_reg;
    logic           v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_kp_reg  <= SQ2'(sq_kp_reg[0]) + SQ2'(sq_kp_reg[1]) + SQ2'(sq_kp_reg[2])
                           + SQ2'(m2_reg);
            rad_km_reg  <= SQ2'(sq_km_reg[0]) + SQ2'(sq_km_reg[1]) + SQ2'(sq_km_reg[2])
                           + SQ2'(m2_reg);
            p2_kk3_reg  <= sq_kk_reg[0] + sq_kk_reg[1] + sq_kk_reg[2];
            p2_kpz3_reg <= sq_kpz_reg[0] + sq_kpz_reg[1] + sq_kpz_reg[2];
            p2_kmz3_reg <= sq_kmz_reg[0] + sq_kmz_reg[1] + sq_kmz_reg[2];
            kpe3_reg    <= kpe2_reg;
            kme3_reg    <= kme2_reg;
            ze3_reg     <= ze2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Pion-hypothesis energies: sqrt(p^2 + m^2), W+1 stages
    // ---------------------------------------------------------------
    logic [SQ2-1:0]   rad1     [2];
    logic [PR-1:0]    pe_root  [2];
    logic [SIDE1-1:0] side1_in, side1_out;
    logic             v_pe;
    logic [EW-1:0]    kpe4, kme4, ze4;
    logic [SQ2-1:0]   p2_kk4, p2_kpz4, p2_kmz4;

    assign rad1[0]  = rad_kp_reg;
    assign rad1[1]  = rad_km_reg;
    assign side1_in = {kpe3_reg, kme3_reg, ze3_reg, p2_kk3_reg, p2_kpz3_reg, p2_kmz3_reg};

    pim_isqrt #(
        .LANES     (2),
        .ROOT_BITS (PR),
        .SIDE_BITS (SIDE1)
    ) u_pion_energy (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (v3_reg),
        .rad_i   (rad1),
        .side_i  (side1_in),
        .valid_o (v_pe),
        .root_o  (pe_root),
        .side_o  (side1_out)
    );

    assign {kpe4, kme4, ze4, p2_kk4, p2_kpz4, p2_kmz4} = side1_out;

    // ---------------------------------------------------------------
    // Stage 4: pair energies
    // ---------------------------------------------------------------
    logic [EB-1:0]  e_reg [NL];
    logic [SQ2-1:0] p2_kk5_reg, p2_kpz5_reg, p2_kmz5_reg;
    logic           v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v_pe;
        end
    end

    // pe_root[0] is the K+ as pion, pe_root[1] the K- as pion
    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg[0]    <= EB'(kpe4) + EB'(kme4);
            e_reg[1]    <= EB'(kpe4) + EB'(pe_root[1]);
            e_reg[2]    <= EB'(kme4) + EB'(pe_root[0]);
            e_reg[3]    <= EB'(kpe4) + EB'(ze4);
            e_reg[4]    <= EB'(kme4) + EB'(ze4);
            p2_kk5_reg  <= p2_kk4;
            p2_kpz5_reg <= p2_kpz4;
            p2_kmz5_reg <= p2_kmz4;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: energy squares
    // ---------------------------------------------------------------
    logic [E2W-1:0] e2_reg [NL];
    logic [SQ2-1:0] p2_kk6_reg, p2_kpz6_reg, p2_kmz6_reg;
    logic           v6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                e2_reg[l] <= e_reg[l] * e_reg[l];
            end
            p2_kk6_reg  <= p2_kk5_reg;
            p2_kpz6_reg <= p2_kpz5_reg;
            p2_kmz6_reg <= p2_kmz5_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: E^2 - |p|^2, clamp negatives to zero
    // ---------------------------------------------------------------
    logic [SQ2-1:0] p2_lane [NL];
    logic [E2W-1:0] diff_reg [NL];
    logic [NL-1:0]  neg_reg;
    logic           v7_reg;

    assign p2_lane[0] = p2_kk6_reg;
    assign p2_lane[1] = p2_kk6_reg;
    assign p2_lane[2] = p2_kk6_reg;
    assign p2_lane[3] = p2_kpz6_reg;
    assign p2_lane[4] = p2_kmz6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                if (e2_reg[l] < E2W'(p2_lane[l])) begin
                    neg_reg[l]  <= 1'b1;
                    diff_reg[l] <= '0;
                end else begin
                    neg_reg[l]  <= 1'b0;
                    diff_reg[l] <= e2_reg[l] - E2W'(p2_lane[l]);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Mass roots, W+2 stages; neg flags ride along
    // ---------------------------------------------------------------
    logic [MR-1:0] mass_root [NL];
    logic [NL-1:0] neg_out;
    logic          v_mass;

    pim_isqrt #(
        .LANES     (NL),
        .ROOT_BITS (MR),
        .SIDE_BITS (NL)
    ) u_mass (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (v7_reg),
        .rad_i   (diff_reg),
        .side_i  (neg_reg),
        .valid_o (v_mass),
        .root_o  (mass_root),
        .side_o  (neg_out)
    );

    // ---------------------------------------------------------------
    // Output register with saturation
    // ---------------------------------------------------------------
    logic [W-2:0]  mass_reg [NL];
    logic [NL-1:0] neg_o_reg;
    logic          m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_mass;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                mass_reg[l] <= (mass_root[l] > MR'(MASS_MAX)) ? MASS_MAX
                                                              : mass_root[l][W-2:0];
            end
            neg_o_reg <= neg_out;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_mass_kk            = mass_reg[0];
    assign m_mass_kplus_piminus = mass_reg[1];
    assign m_mass_kminus_piplus = mass_reg[2];
    assign m_mass_kplus_pizero  = mass_reg[3];
    assign m_mass_kminus_pizero = mass_reg[4];
    assign m_neg_kk             = neg_o_reg[0];
    assign m_neg_kplus_piminus  = neg_o_reg[1];
    assign m_neg_kminus_piplus  = neg_o_reg[2];
    assign m_neg_kplus_pizero   = neg_o_reg[3];
    assign m_neg_kminus_pizero  = neg_o_reg[4];

endmodule

[design/pim_checker.sv]
`timescale 1ns / 1ps
`include "pair_invariant_mass_unit_macros.svh"

module pim_checker #(
    parameter int WORD_BITS = pim_pkg::WORD_BITS_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [WORD_BITS-2:0] m_mass_kk,
    input logic [WORD_BITS-2:0] m_mass_kplus_piminus,
    input logic [WORD_BITS-2:0] m_mass_kminus_piplus,
    input logic [WORD_BITS-2:0] m_mass_kplus_pizero,
    input logic [WORD_BITS-2:0] m_mass_kminus_pizero,
    input logic                 m_neg_kk,
    input logic                 m_neg_kplus_piminus,
    input logic                 m_neg_kminus_piplus,
    input logic                 m_neg_kplus_pizero,
    input logic                 m_neg_kminus_pizero
);

    // reset empties the result side
    `PIM_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

    // intake stalls only behind a blocked result
    `PIM_ASSERT(a_stall_cause, !s_ready |-> (m_valid && !m_ready), "s_ready low without stall")

    // a clamped mass reads zero
    `PIM_ASSERT(a_neg_zero, m_valid |-> ((!m_neg_kk || m_mass_kk == '0) && (!m_neg_kplus_piminus || m_mass_kplus_piminus == '0) && (!m_neg_kminus_piplus || m_mass_kminus_piplus == '0) && (!m_neg_kplus_pizero || m_mass_kplus_pizero == '0) && (!m_neg_kminus_pizero || m_mass_kminus_pizero == '0)), "neg flag with nonzero mass")

    // stalled result holds
    `PIM_ASSERT(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_mass_kk) && $stable(m_mass_kplus_pizero)), "stalled result changed")

endmodule

bind pair_invariant_mass_unit pim_checker #(.WORD_BITS(WORD_BITS)) u_pim_checker (.*);
